/* hw/rtl/dsar_pkg.sv */
package dsar_pkg;

    localparam int FRAC_BITS = 8;

    localparam int TGT_W   = 25;
    localparam int SPEED_W = 24;
    localparam int TIME_W  = 32;
    localparam int DT_W    = 7;
    localparam int ACC_W   = 20;
    localparam int FREQ_W  = 16;
    localparam int CNT_W   = 32;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 2;

    // step = floor(accel * dt * 2^FRAC_BITS / 1000), 1000 = 8 * 125
    localparam int STEP_SHIFT       = FRAC_BITS - 3;
    localparam int STEP_X_W         = ACC_W + DT_W + STEP_SHIFT;
    localparam int STEP_RECIP_W     = 26;
    localparam int STEP_RECIP_SHIFT = 32;
    localparam int STEP_PROD_W      = STEP_X_W + STEP_RECIP_W;
    localparam int STEP_W           = 25;

    // odometry = floor(speed * dt / (1000 * 2^FRAC_BITS))
    localparam int ODO_Y_W         = SPEED_W + DT_W;
    localparam int ODO_SHIFT       = FRAC_BITS + 3;
    localparam int ODO_Z_W         = ODO_Y_W - ODO_SHIFT;
    localparam int ODO_RECIP_W     = 21;
    localparam int ODO_RECIP_SHIFT = 27;
    localparam int ODO_PROD_W      = ODO_Z_W + ODO_RECIP_W;
    localparam int ODO_Q_W         = 14;
    localparam int ODO_REM_W       = ODO_Z_W + 1;

    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 26'd34359738;
    localparam logic [ODO_RECIP_W-1:0]  ODO_RECIP  = 21'd1073741;
    localparam logic [6:0]              DIV_BASE   = 7'd125;

    localparam logic [DT_W-1:0]    DT_MAX_MS     = 7'd100;
    localparam logic [DT_W-1:0]    DT_DEFAULT_MS = 7'd10;
    localparam logic [FREQ_W-1:0]  FREQ_MAX      = 16'd50000;
    localparam logic [FREQ_W-1:0]  FREQ_MIN      = 16'd1;
    localparam logic [FREQ_W-1:0]  FREQ_ON_MIN   = 16'd10;
    localparam logic [SPEED_W-1:0] SPEED_SAT     = 24'hFFFFFF;
    localparam logic [SPEED_W-1:0] MIN_SPEED     = SPEED_W'(10 << FRAC_BITS);
    localparam logic [SPEED_W-1:0] ROUND_HALF    = SPEED_W'(1 << (FRAC_BITS - 1));
    localparam logic [ACC_W-1:0]   ACCEL_RESET   = 20'd20000;

    localparam logic [IDX_W-1:0] REG_MAX_ACCEL   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_REV    = 2'd1;
    localparam logic [IDX_W-1:0] REG_RIGHT_REV   = 2'd2;

    // pipeline stages
    localparam int NSTAGE  = 9;
    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_REC  = 2;
    localparam int ST_STEP = 3;
    localparam int ST_RAMP = 4;
    localparam int ST_FREQ = 5;
    localparam int ST_ODOM = 6;
    localparam int ST_CNT  = 7;
    localparam int ST_OUT  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [NSTAGE-1:0] vld;
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] go;
    } t_pipe_ctl;

    typedef struct packed {
        t_cmd               cmd;
        logic [DT_W-1:0]    dt;
        logic               both_zero;
        logic [SPEED_W-1:0] lmag;
        logic               lneg;
        logic [SPEED_W-1:0] rmag;
        logic               rneg;
    } t_front;

    typedef struct packed {
        logic               dir;
        logic [SPEED_W-1:0] speed;
        logic [FREQ_W-1:0]  freq;
        logic [CNT_W-1:0]   count;
    } t_lane_out;

endpackage

/* hw/rtl/dsar_step.sv */
module dsar_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dsar_pkg::t_pipe_ctl         i_ctl,
    input  logic [dsar_pkg::CMD_W-1:0]  i_command,
    input  logic [dsar_pkg::TGT_W-1:0]  i_left_target,
    input  logic [dsar_pkg::TGT_W-1:0]  i_right_target,
    input  logic [dsar_pkg::TIME_W-1:0] i_now_ms,
    input  logic [dsar_pkg::ACC_W-1:0]  i_max_accel,
    output dsar_pkg::t_front            o_front,
    output logic [dsar_pkg::STEP_W-1:0] o_step
);
    import dsar_pkg::*;

    localparam int MUL_W = ACC_W + DT_W;

    function automatic logic [SPEED_W:0] f_mag(input logic [TGT_W-1:0] v);
        logic [TGT_W-1:0] m;
        m = v[TGT_W-1] ? (~v + TGT_W'(1)) : v;
        // only the most negative code overflows 24 bits
        if (m[TGT_W-1]) begin
            return {v[TGT_W-1], SPEED_SAT};
        end
        return {v[TGT_W-1], m[SPEED_W-1:0]};
    endfunction

    logic [TIME_W-1:0]      r_last_time;
    logic [TIME_W-1:0]      n_diff;
    t_front                 n_s0;
    t_front                 r_s0;
    t_front                 r_s1;
    t_front                 r_s2;
    t_front                 r_s3;
    logic [MUL_W-1:0]       r_s1_p;
    logic [STEP_X_W-1:0]    n_s2_x;
    logic [STEP_X_W-1:0]    r_s2_x;
    logic [STEP_PROD_W-1:0] r_s2_prod;
    logic [STEP_W-1:0]      n_q0;
    logic [STEP_X_W-1:0]    n_rem;
    logic [STEP_W-1:0]      n_step;
    logic [STEP_W-1:0]      r_s3_step;
    logic [SPEED_W:0]       n_lm;
    logic [SPEED_W:0]       n_rm;

    always_comb begin
        n_diff = i_now_ms - r_last_time;
        n_lm   = f_mag(i_left_target);
        n_rm   = f_mag(i_right_target);
        n_s0.cmd       = t_cmd'(i_command);
        n_s0.both_zero = (i_left_target == '0) && (i_right_target == '0);
        n_s0.lneg      = n_lm[SPEED_W];
        n_s0.lmag      = n_lm[SPEED_W-1:0];
        n_s0.rneg      = n_rm[SPEED_W];
        n_s0.rmag      = n_rm[SPEED_W-1:0];
        if ((n_diff == '0) || (n_diff > TIME_W'(DT_MAX_MS))) begin
            n_s0.dt = DT_DEFAULT_MS;
        end else begin
            n_s0.dt = n_diff[DT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else if (i_ctl.go[ST_IN] && (t_cmd'(i_command) == CMD_SET)) begin
            r_last_time <= i_now_ms;
        end
    end

    assign n_s2_x = {r_s1_p, {STEP_SHIFT{1'b0}}};

    // reciprocal quotient is exact or one low
    always_comb begin
        n_q0   = r_s2_prod[STEP_RECIP_SHIFT +: STEP_W];
        n_rem  = r_s2_x - (STEP_X_W'(n_q0) * STEP_X_W'(DIV_BASE));
        n_step = n_q0 + STEP_W'(n_rem >= STEP_X_W'(DIV_BASE));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_IN]) begin
            r_s0 <= n_s0;
        end
        if (i_ctl.en[ST_MUL]) begin
            r_s1   <= r_s0;
            r_s1_p <= MUL_W'(i_max_accel) * MUL_W'(r_s0.dt);
        end
        if (i_ctl.en[ST_REC]) begin
            r_s2      <= r_s1;
            r_s2_x    <= n_s2_x;
            r_s2_prod <= STEP_PROD_W'(n_s2_x) * STEP_PROD_W'(STEP_RECIP);
        end
        if (i_ctl.en[ST_STEP]) begin
            r_s3      <= r_s2;
            r_s3_step <= n_step;
        end
    end

    assign o_front = r_s3;
    assign o_step  = r_s3_step;

    ap_step_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[ST_REC] |-> (n_rem < STEP_X_W'(2 * DIV_BASE)))
        else $error("step quotient correction out of range");

endmodule

/* hw/rtl/dsar_lane.sv */
module dsar_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dsar_pkg::t_pipe_ctl          i_ctl,
    input  dsar_pkg::t_cmd               i_cmd,
    input  logic [dsar_pkg::DT_W-1:0]    i_dt,
    input  logic                         i_both_zero,
    input  logic [dsar_pkg::SPEED_W-1:0] i_mag,
    input  logic                         i_neg,
    input  logic [dsar_pkg::STEP_W-1:0]  i_step,
    input  logic                         i_reversed,
    output dsar_pkg::t_lane_out          o_lane
);
    import dsar_pkg::*;

    localparam int FREQ_RAW_W = SPEED_W + 1 - FRAC_BITS;

    logic [SPEED_W-1:0]    r_speed;
    logic [SPEED_W-1:0]    n_speed;
    logic                  r_dir;
    logic                  n_dir;
    logic [SPEED_W-1:0]    n_ramp;
    logic [SPEED_W-1:0]    n_diff;
    t_cmd                  r_s4_cmd;
    logic [DT_W-1:0]       r_s4_dt;

    logic [FREQ_W-1:0]     r_freq;
    logic [FREQ_W-1:0]     n_freq;
    logic [SPEED_W:0]      n_round;
    logic [FREQ_RAW_W-1:0] n_fraw;
    t_cmd                  r_s5_cmd;
    logic [SPEED_W-1:0]    r_s5_speed;
    logic                  r_s5_dir;
    logic [ODO_Y_W-1:0]    r_s5_y;

    t_cmd                  r_s6_cmd;
    logic [SPEED_W-1:0]    r_s6_speed;
    logic                  r_s6_dir;
    logic [FREQ_W-1:0]     r_s6_freq;
    logic [ODO_Z_W-1:0]    r_s6_z;
    logic [ODO_PROD_W-1:0] r_s6_prod;

    logic [ODO_Q_W-1:0]    n_q0;
    logic [ODO_REM_W-1:0]  n_rem;
    logic [ODO_Q_W-1:0]    n_inc;
    logic [CNT_W-1:0]      r_count;
    logic [SPEED_W-1:0]    r_s7_speed;
    logic                  r_s7_dir;
    logic [FREQ_W-1:0]     r_s7_freq;

    // ramp stage
    always_comb begin
        if (i_mag >= r_speed) begin
            n_diff = i_mag - r_speed;
            n_ramp = (STEP_W'(n_diff) <= i_step) ? i_mag
                                                 : r_speed + i_step[SPEED_W-1:0];
        end else begin
            n_diff = r_speed - i_mag;
            n_ramp = (STEP_W'(n_diff) <= i_step) ? i_mag
                                                 : r_speed - i_step[SPEED_W-1:0];
        end
        n_speed = r_speed;
        n_dir   = r_dir;
        case (i_cmd)
            CMD_SET: begin
                n_speed = i_both_zero ? '0 : n_ramp;
                n_dir   = (!i_neg) ^ i_reversed;
            end
            CMD_STOP: begin
                n_speed = '0;
            end
            default: begin
                n_speed = r_speed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_dir   <= 1'b0;
        end else if (i_ctl.go[ST_RAMP]) begin
            r_speed <= n_speed;
            r_dir   <= n_dir;
        end
    end

    // frequency stage
    always_comb begin
        n_round = {1'b0, r_speed} + (SPEED_W + 1)'(ROUND_HALF);
        n_fraw  = n_round[SPEED_W:FRAC_BITS];
        if (n_fraw > FREQ_RAW_W'(FREQ_MAX)) begin
            n_freq = FREQ_MAX;
        end else if (n_fraw == '0) begin
            n_freq = FREQ_MIN;
        end else begin
            n_freq = n_fraw[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_MIN;
        end else if (i_ctl.go[ST_FREQ] && (r_s4_cmd == CMD_SET) && (r_speed >= MIN_SPEED)) begin
            r_freq <= n_freq;
        end
    end

    // odometry correction and counter
    always_comb begin
        n_q0  = r_s6_prod[ODO_RECIP_SHIFT +: ODO_Q_W];
        n_rem = ODO_REM_W'(r_s6_z) - (ODO_REM_W'(n_q0) * ODO_REM_W'(DIV_BASE));
        n_inc = n_q0 + ODO_Q_W'(n_rem >= ODO_REM_W'(DIV_BASE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.go[ST_CNT]) begin
            case (r_s6_cmd)
                CMD_SET: begin
                    r_count <= r_count + CNT_W'(n_inc);
                end
                CMD_CLEAR: begin
                    r_count <= '0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_RAMP]) begin
            r_s4_cmd <= i_cmd;
            r_s4_dt  <= i_dt;
        end
        if (i_ctl.en[ST_FREQ]) begin
            r_s5_cmd   <= r_s4_cmd;
            r_s5_speed <= r_speed;
            r_s5_dir   <= r_dir;
            r_s5_y     <= ODO_Y_W'(r_speed) * ODO_Y_W'(r_s4_dt);
        end
        if (i_ctl.en[ST_ODOM]) begin
            r_s6_cmd   <= r_s5_cmd;
            r_s6_speed <= r_s5_speed;
            r_s6_dir   <= r_s5_dir;
            r_s6_freq  <= r_freq;
            r_s6_z     <= r_s5_y[ODO_Y_W-1:ODO_SHIFT];
            r_s6_prod  <= ODO_PROD_W'(r_s5_y[ODO_Y_W-1:ODO_SHIFT]) * ODO_PROD_W'(ODO_RECIP);
        end
        if (i_ctl.en[ST_CNT]) begin
            r_s7_speed <= r_s6_speed;
            r_s7_dir   <= r_s6_dir;
            r_s7_freq  <= r_s6_freq;
        end
    end

    assign o_lane.dir   = r_s7_dir;
    assign o_lane.speed = r_s7_speed;
    assign o_lane.freq  = r_s7_freq;
    assign o_lane.count = r_count;

    ap_odo_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[ST_ODOM] |-> (n_rem < ODO_REM_W'(2 * DIV_BASE)))
        else $error("odometry quotient correction out of range");

    ap_on_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld[ST_CNT] && (r_s7_speed >= MIN_SPEED)) |-> (r_s7_freq >= FREQ_ON_MIN))
        else $error("pulse enabled with stale frequency");

endmodule

/* hw/rtl/dsar_merge.sv */
module dsar_merge (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  dsar_pkg::t_lane_out               i_left,
    input  dsar_pkg::t_lane_out               i_right,
    output logic                              o_left_dir,
    output logic                              o_right_dir,
    output logic                              o_left_pulse_on,
    output logic                              o_right_pulse_on,
    output logic [dsar_pkg::FREQ_W-1:0]       o_left_freq,
    output logic [dsar_pkg::FREQ_W-1:0]       o_right_freq,
    output logic signed [dsar_pkg::TGT_W-1:0] o_left_speed_report,
    output logic signed [dsar_pkg::TGT_W-1:0] o_right_speed_report,
    output logic [dsar_pkg::CNT_W-1:0]        o_left_count,
    output logic [dsar_pkg::CNT_W-1:0]        o_right_count
);
    import dsar_pkg::*;

    function automatic logic [TGT_W-1:0] f_report(input logic d,
                                                  input logic [SPEED_W-1:0] s);
        logic [TGT_W-1:0] v;
        v = {1'b0, s};
        return d ? v : (~v + TGT_W'(1));
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_left_dir           <= i_left.dir;
            o_right_dir          <= i_right.dir;
            o_left_pulse_on      <= (i_left.speed >= MIN_SPEED);
            o_right_pulse_on     <= (i_right.speed >= MIN_SPEED);
            o_left_freq          <= i_left.freq;
            o_right_freq         <= i_right.freq;
            o_left_speed_report  <= signed'(f_report(i_left.dir, i_left.speed));
            o_right_speed_report <= signed'(f_report(i_right.dir, i_right.speed));
            o_left_count         <= i_left.count;
            o_right_count        <= i_right.count;
        end
    end

endmodule

/* hw/rtl/dual_stepper_accel_ramp.sv */
// Two-channel stepper speed ramp.
// Input channel (i_valid / o_stall) takes one command beat: set speeds with
// signed Q16.8 targets and a millisecond timestamp, stop both, or clear
// odometry. Output channel (o_valid / i_stall) returns one beat per command
// with direction pins, pulse enables, step frequencies, signed ramped speeds
// and the two odometry counts as they stand after that command.
// Configuration (i_cfg_wen / i_cfg_idx / i_cfg_data) writes max_accel (0),
// left_reversed (1) and right_reversed (2); other indexes are
// ignored. Write only while no command is in flight.
// Throughput is one command per cycle while the receiver does not stall, set
// by the nine-stage pipeline: step size, ramp, frequency and odometry each
// have their own stages, the speed state closes its loop in the ramp stage
// and the counters in the count stage.
// While the receiver stalls, the output beat holds and earlier stages keep
// filling into empty slots; o_stall rises once all nine stages hold a beat.
// Reset (synchronous, active low) zeroes speeds, counts and the time stamp,
// sets both frequencies to 1 Hz, the direction state low, max_accel to 20000.
module dual_stepper_accel_ramp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [dsar_pkg::CMD_W-1:0]        i_command,
    input  logic signed [dsar_pkg::TGT_W-1:0] i_left_target,
    input  logic signed [dsar_pkg::TGT_W-1:0] i_right_target,
    input  logic [dsar_pkg::TIME_W-1:0]       i_now_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_left_dir,
    output logic                              o_right_dir,
    output logic                              o_left_pulse_on,
    output logic                              o_right_pulse_on,
    output logic [dsar_pkg::FREQ_W-1:0]       o_left_freq,
    output logic [dsar_pkg::FREQ_W-1:0]       o_right_freq,
    output logic signed [dsar_pkg::TGT_W-1:0] o_left_speed_report,
    output logic signed [dsar_pkg::TGT_W-1:0] o_right_speed_report,
    output logic [dsar_pkg::CNT_W-1:0]        o_left_count,
    output logic [dsar_pkg::CNT_W-1:0]        o_right_count,
    input  logic                              i_cfg_wen,
    input  logic [dsar_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [dsar_pkg::CFG_W-1:0]        i_cfg_data
);
    import dsar_pkg::*;

    logic [ACC_W-1:0]  r_max_accel;
    logic              r_left_rev;
    logic              r_right_rev;
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    t_pipe_ctl         n_ctl;
    t_front            w_front;
    logic [STEP_W-1:0] w_step;
    t_lane_out         w_left;
    t_lane_out         w_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_accel <= ACCEL_RESET;
            r_left_rev  <= 1'b0;
            r_right_rev <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_MAX_ACCEL: r_max_accel <= i_cfg_data[ACC_W-1:0];
                REG_LEFT_REV:  r_left_rev  <= i_cfg_data[0];
                REG_RIGHT_REV: r_right_rev <= i_cfg_data[0];
                default:       r_max_accel <= r_max_accel;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        n_ctl.vld          = r_vld;
        n_ctl.en[ST_OUT]   = !r_vld[ST_OUT] || !i_stall;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            n_ctl.en[k] = !r_vld[k] || n_ctl.en[k+1];
        end
        n_ctl.go[ST_IN] = n_ctl.en[ST_IN] && i_valid;
        n_vld[ST_IN]    = n_ctl.en[ST_IN] ? i_valid : r_vld[ST_IN];
        for (int k = 1; k < NSTAGE; k++) begin
            n_ctl.go[k] = n_ctl.en[k] && r_vld[k-1];
            n_vld[k]    = n_ctl.en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !n_ctl.en[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    dsar_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (n_ctl),
        .i_command      (i_command),
        .i_left_target  (i_left_target),
        .i_right_target (i_right_target),
        .i_now_ms       (i_now_ms),
        .i_max_accel    (r_max_accel),
        .o_front        (w_front),
        .o_step         (w_step)
    );

    dsar_lane u_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (n_ctl),
        .i_cmd       (w_front.cmd),
        .i_dt        (w_front.dt),
        .i_both_zero (w_front.both_zero),
        .i_mag       (w_front.lmag),
        .i_neg       (w_front.lneg),
        .i_step      (w_step),
        .i_reversed  (r_left_rev),
        .o_lane      (w_left)
    );

    dsar_lane u_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (n_ctl),
        .i_cmd       (w_front.cmd),
        .i_dt        (w_front.dt),
        .i_both_zero (w_front.both_zero),
        .i_mag       (w_front.rmag),
        .i_neg       (w_front.rneg),
        .i_step      (w_step),
        .i_reversed  (r_right_rev),
        .o_lane      (w_right)
    );

    dsar_merge u_merge (
        .i_clk                (i_clk),
        .i_en                 (n_ctl.en[ST_OUT]),
        .i_left               (w_left),
        .i_right              (w_right),
        .o_left_dir           (o_left_dir),
        .o_right_dir          (o_right_dir),
        .o_left_pulse_on      (o_left_pulse_on),
        .o_right_pulse_on     (o_right_pulse_on),
        .o_left_freq          (o_left_freq),
        .o_right_freq         (o_right_freq),
        .o_left_speed_report  (o_left_speed_report),
        .o_right_speed_report (o_right_speed_report),
        .o_left_count         (o_left_count),
        .o_right_count        (o_right_count)
    );

    ap_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty pipeline slot");

    ap_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    ap_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[ST_IN])
        else $error("accepted beat lost at pipeline entry");

endmodule

/* test/dsar_ramp_checker.sv */
module dsar_ramp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [dsar_pkg::CMD_W-1:0]        i_command,
    input  logic signed [dsar_pkg::TGT_W-1:0] i_left_target,
    input  logic signed [dsar_pkg::TGT_W-1:0] i_right_target,
    input  logic [dsar_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic                              o_left_dir,
    input  logic                              o_right_dir,
    input  logic                              o_left_pulse_on,
    input  logic                              o_right_pulse_on,
    input  logic [dsar_pkg::FREQ_W-1:0]       o_left_freq,
    input  logic [dsar_pkg::FREQ_W-1:0]       o_right_freq,
    input  logic signed [dsar_pkg::TGT_W-1:0] o_left_speed_report,
    input  logic signed [dsar_pkg::TGT_W-1:0] o_right_speed_report,
    input  logic [dsar_pkg::CNT_W-1:0]        o_left_count,
    input  logic [dsar_pkg::CNT_W-1:0]        o_right_count,
    input  logic                              i_cfg_wen,
    input  logic [dsar_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [dsar_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_mismatches,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dsar_pkg::*;

    localparam logic [63:0] MS_PER_S    = 64'd1000;
    localparam logic [63:0] ODO_DIV     = MS_PER_S << FRAC_BITS;

    typedef struct packed {
        logic               ldir;
        logic               rdir;
        logic               lon;
        logic               ron;
        logic [FREQ_W-1:0]  lfreq;
        logic [FREQ_W-1:0]  rfreq;
        logic [TGT_W-1:0]   lrep;
        logic [TGT_W-1:0]   rrep;
        logic [CNT_W-1:0]   lcnt;
        logic [CNT_W-1:0]   rcnt;
    } t_motor_status;

    t_motor_status expected_status_q[$];
    t_motor_status seen;
    t_motor_status want;
    int mismatch_cnt = 0;
    int pending_cnt = 0;

    logic [ACC_W-1:0]   accel;
    logic               rev_l;
    logic               rev_r;
    logic [SPEED_W-1:0] spd_l;
    logic [SPEED_W-1:0] spd_r;
    logic [TIME_W-1:0]  stamp_ms;
    logic               dir_l;
    logic               dir_r;
    logic [FREQ_W-1:0]  freq_l;
    logic [FREQ_W-1:0]  freq_r;
    logic [CNT_W-1:0]   odo_l;
    logic [CNT_W-1:0]   odo_r;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;

    function automatic logic [SPEED_W-1:0] target_speed(input logic [TGT_W-1:0] raw);
        logic [TGT_W:0] m;
        m = raw[TGT_W-1] ? ((TGT_W+1)'(0) - {raw[TGT_W-1], raw}) : {1'b0, raw};
        return (m > (TGT_W+1)'(SPEED_SAT)) ? SPEED_SAT : m[SPEED_W-1:0];
    endfunction

    function automatic logic [SPEED_W-1:0] slew(input logic [SPEED_W-1:0] goal,
                                                 input logic [SPEED_W-1:0] cur,
                                                 input logic [63:0] step);
        if (goal >= cur) begin
            return (64'(goal - cur) <= step) ? goal : SPEED_W'(64'(cur) + step);
        end else begin
            return (64'(cur - goal) <= step) ? goal : SPEED_W'(64'(cur) - step);
        end
    endfunction

    function automatic logic [FREQ_W-1:0] step_rate(input logic [SPEED_W-1:0] s);
        logic [63:0] f;
        f = (64'(s) + 64'(ROUND_HALF)) >> FRAC_BITS;
        if (f < 64'(FREQ_MIN)) f = 64'(FREQ_MIN);
        if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
        return f[FREQ_W-1:0];
    endfunction

    function automatic logic [TGT_W-1:0] signed_speed(input logic [SPEED_W-1:0] s,
                                                       input logic dir);
        return dir ? {1'b0, s} : (TGT_W'(0) - {1'b0, s});
    endfunction

    task automatic reset_motors;
        accel    = ACCEL_RESET;
        rev_l    = 1'b0;
        rev_r    = 1'b0;
        spd_l    = '0;
        spd_r    = '0;
        stamp_ms = '0;
        dir_l    = 1'b0;
        dir_r    = 1'b0;
        freq_l   = FREQ_MIN;
        freq_r   = FREQ_MIN;
        odo_l    = '0;
        odo_r    = '0;
    endtask

    task automatic apply_command(input t_cmd cmd, input logic [TGT_W-1:0] lt,
                                 input logic [TGT_W-1:0] rt, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] dt;
        logic [63:0]       step;
        t_motor_status     st;
        case (cmd)
            CMD_SET: begin
                dt = now - stamp_ms;
                if (dt == 0 || dt > TIME_W'(DT_MAX_MS)) dt = TIME_W'(DT_DEFAULT_MS);
                stamp_ms = now;
                dir_l = ~lt[TGT_W-1] ^ rev_l;
                dir_r = ~rt[TGT_W-1] ^ rev_r;
                step = ((64'(accel) * 64'(dt)) << FRAC_BITS) / MS_PER_S;
                // both targets zero is an immediate stop, no ramp
                if (lt == '0 && rt == '0) begin
                    spd_l = '0;
                    spd_r = '0;
                end else begin
                    spd_l = slew(target_speed(lt), spd_l, step);
                    spd_r = slew(target_speed(rt), spd_r, step);
                end
                if (spd_l >= MIN_SPEED) freq_l = step_rate(spd_l);
                if (spd_r >= MIN_SPEED) freq_r = step_rate(spd_r);
                odo_l = odo_l + CNT_W'((64'(spd_l) * 64'(dt)) / ODO_DIV);
                odo_r = odo_r + CNT_W'((64'(spd_r) * 64'(dt)) / ODO_DIV);
            end
            CMD_STOP: begin
                spd_l = '0;
                spd_r = '0;
            end
            CMD_CLEAR: begin
                odo_l = '0;
                odo_r = '0;
            end
            default: ;
        endcase
        st.ldir  = dir_l;
        st.rdir  = dir_r;
        st.lon   = spd_l >= MIN_SPEED;
        st.ron   = spd_r >= MIN_SPEED;
        st.lfreq = freq_l;
        st.rfreq = freq_r;
        st.lrep  = signed_speed(spd_l, dir_l);
        st.rrep  = signed_speed(spd_r, dir_r);
        st.lcnt  = odo_l;
        st.rcnt  = odo_r;
        expected_status_q.push_back(st);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_cnt++;
            $display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    initial reset_motors();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_motors();
            expected_status_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                seen.ldir  = o_left_dir;
                seen.rdir  = o_right_dir;
                seen.lon   = o_left_pulse_on;
                seen.ron   = o_right_pulse_on;
                seen.lfreq = o_left_freq;
                seen.rfreq = o_right_freq;
                seen.lrep  = o_left_speed_report;
                seen.rrep  = o_right_speed_report;
                seen.lcnt  = o_left_count;
                seen.rcnt  = o_right_count;
                if (expected_status_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t status beat with none expected, actual %0h",
                             $time, seen);
                end else begin
                    want = expected_status_q.pop_front();
                    compare_field("left_dir", 32'(want.ldir), 32'(seen.ldir));
                    compare_field("right_dir", 32'(want.rdir), 32'(seen.rdir));
                    compare_field("left_pulse_on", 32'(want.lon), 32'(seen.lon));
                    compare_field("right_pulse_on", 32'(want.ron), 32'(seen.ron));
                    compare_field("left_freq", 32'(want.lfreq), 32'(seen.lfreq));
                    compare_field("right_freq", 32'(want.rfreq), 32'(seen.rfreq));
                    compare_field("left_speed_report", 32'(want.lrep), 32'(seen.lrep));
                    compare_field("right_speed_report", 32'(want.rrep), 32'(seen.rrep));
                    compare_field("left_count", want.lcnt, seen.lcnt);
                    compare_field("right_count", want.rcnt, seen.rcnt);
                end
            end
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    REG_MAX_ACCEL: accel = i_cfg_data[ACC_W-1:0];
                    REG_LEFT_REV:  rev_l = i_cfg_data[0];
                    REG_RIGHT_REV: rev_r = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                apply_command(t_cmd'(i_command), i_left_target, i_right_target, i_now_ms);
            end
        end
        pending_cnt = expected_status_q.size();
    end

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsar_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 2'd3;
    localparam logic [IDX_W-1:0]  REG_UNUSED  = 2'd3;
    localparam logic [TGT_W-1:0]  TGT_MAX     = 25'd12800000;
    localparam logic [TGT_W-1:0]  TGT_MIN_RAW = 25'h1000000;
    localparam logic [TGT_W-1:0]  TGT_TOP_RAW = 25'h0FFFFFF;
    localparam logic [ACC_W-1:0]  ACCEL_TOP   = 20'd1000000;
    localparam int                HOLD_LEN    = 60;
    localparam int                QUIET_LIMIT = 2000;
    localparam int                TAIL_CYCLES = 20;
    localparam int                PHASE_ITEMS = 365;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [CMD_W-1:0]         i_command = '0;
    logic signed [TGT_W-1:0]  i_left_target = '0;
    logic signed [TGT_W-1:0]  i_right_target = '0;
    logic [TIME_W-1:0]        i_now_ms = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_left_dir;
    logic                     o_right_dir;
    logic                     o_left_pulse_on;
    logic                     o_right_pulse_on;
    logic [FREQ_W-1:0]        o_left_freq;
    logic [FREQ_W-1:0]        o_right_freq;
    logic signed [TGT_W-1:0]  o_left_speed_report;
    logic signed [TGT_W-1:0]  o_right_speed_report;
    logic [CNT_W-1:0]         o_left_count;
    logic [CNT_W-1:0]         o_right_count;
    logic                     i_cfg_wen = 1'b0;
    logic [IDX_W-1:0]         i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;

    int mismatches;
    int pending;
    int send_idle_pct = 14;
    int recv_idle_pct = 64;
    logic hold_go = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    logic [TGT_W-1:0]  last_left = '0;
    logic [TGT_W-1:0]  last_right = '0;

    dual_stepper_accel_ramp i_dut (.*);

    dsar_ramp_checker i_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_command            (i_command),
        .i_left_target        (i_left_target),
        .i_right_target       (i_right_target),
        .i_now_ms             (i_now_ms),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_left_dir           (o_left_dir),
        .o_right_dir          (o_right_dir),
        .o_left_pulse_on      (o_left_pulse_on),
        .o_right_pulse_on     (o_right_pulse_on),
        .o_left_freq          (o_left_freq),
        .o_right_freq         (o_right_freq),
        .o_left_speed_report  (o_left_speed_report),
        .o_right_speed_report (o_right_speed_report),
        .o_left_count         (o_left_count),
        .o_right_count        (o_right_count),
        .i_cfg_wen            (i_cfg_wen),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_mismatches         (mismatches),
        .o_pending            (pending)
    );

    always #10 i_clk = ~i_clk;

    // receiver: one long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_go && hold_cnt < HOLD_LEN) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [TGT_W-1:0] lt,
                             input logic [TGT_W-1:0] rt, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_left_target  <= lt;
        i_right_target <= rt;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [TGT_W-1:0] pick_target(input logic [TGT_W-1:0] prev);
        logic [TGT_W-1:0] mag;
        case ($urandom_range(9))
            0:       mag = '0;
            1, 2:    return prev;
            3:       mag = TGT_W'($urandom_range(2900, 2200));
            4:       mag = TGT_MAX;
            5:       mag = TGT_W'($urandom_range(5000));
            default: mag = TGT_W'($urandom_range(12800000));
        endcase
        return $urandom_range(1) ? (TGT_W'(0) - mag) : mag;
    endfunction

    task automatic random_beat;
        int pick;
        pick = $urandom_range(99);
        if (pick < 78) begin
            case ($urandom_range(19))
                0, 1:    ;
                2:       clock_ms = clock_ms + $urandom_range(5000, 101);
                3:       clock_ms = $urandom;
                default: clock_ms = clock_ms + $urandom_range(100, 1);
            endcase
            if ($urandom_range(19) == 0) begin
                last_left  = '0;
                last_right = '0;
            end else begin
                last_left  = pick_target(last_left);
                last_right = pick_target(last_right);
            end
            send_beat(CMD_SET, last_left, last_right, clock_ms);
        end else begin
            send_beat(pick < 86 ? CMD_STOP : (pick < 93 ? CMD_CLEAR : CMD_UNKNOWN),
                      TGT_W'($urandom), TGT_W'($urandom), $urandom);
        end
    endtask

    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [ACC_W-1:0] accel, input logic lrev, input logic rrev);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= REG_MAX_ACCEL;
        i_cfg_data <= CFG_W'(accel);
        @(posedge i_clk);
        i_cfg_idx  <= REG_LEFT_REV;
        i_cfg_data <= (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(lrev);
        @(posedge i_clk);
        i_cfg_idx  <= REG_RIGHT_REV;
        i_cfg_data <= (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(rrev);
        @(posedge i_clk);
        i_cfg_idx  <= REG_UNUSED;
        i_cfg_data <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats with reset register values
        send_beat(CMD_SET, '0, '0, 32'd0);
        send_beat(CMD_SET, TGT_MAX, -TGT_MAX, 32'd5);
        send_beat(CMD_SET, TGT_MAX, -TGT_MAX, 32'd105);
        send_beat(CMD_SET, TGT_MAX, -TGT_MAX, 32'd206);
        send_beat(CMD_SET, TGT_MIN_RAW, TGT_TOP_RAW, 32'd250);
        send_beat(CMD_UNKNOWN, 25'h1555555, 25'h0AAAAAA, 32'hAAAA5555);
        send_beat(CMD_STOP, 25'h0AAAAAA, 25'h1555555, 32'h5555AAAA);
        send_beat(CMD_SET, 25'h0001080, -25'h0000A00, 32'd260);
        send_beat(CMD_SET, 25'h00009FF, 25'h0000001, 32'd270);
        send_beat(CMD_CLEAR, '1, '1, '1);
        send_beat(CMD_SET, '0, 25'd50000, 32'hFFFFFFF0);
        send_beat(CMD_SET, '0, 25'd50000, 32'h00000005);
        send_beat(CMD_SET, -25'd1, 25'd50000, 32'h00000005);
        send_beat(CMD_SET, '0, '0, 32'h00000006);
        send_beat(CMD_SET, TGT_TOP_RAW, TGT_TOP_RAW, 32'd106);
        send_beat(CMD_SET, -TGT_MAX, TGT_MAX, 32'd206);
        send_beat(CMD_STOP, '0, '0, '0);
        send_beat(CMD_CLEAR, '0, '0, '0);
        clock_ms = 32'd206;
        drain_results();

        // no acceleration: only stops and zero targets move the speeds
        set_regs('0, 1'b1, 1'b1);
        repeat (40) random_beat();
        drain_results();

        set_regs(ACCEL_TOP, 1'b1, 1'b0);
        repeat (PHASE_ITEMS) random_beat();
        drain_results();

        send_idle_pct = 64;
        recv_idle_pct = 14;
        set_regs(ACC_W'($urandom_range(60000, 500)), 1'b0, 1'b1);
        repeat (PHASE_ITEMS) random_beat();
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(ACC_W'($urandom_range(1000000, 1)), 1'($urandom), 1'($urandom));
        hold_go <= 1'b1;
        repeat (PHASE_ITEMS) random_beat();
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
